// File: sv/id3u8_pkg.sv
`default_nettype none

package id3u8_pkg;

  localparam int RUN_MAX = 6;
  localparam int CNT_W   = 3;
  localparam int CP_W    = 21;

  localparam logic [1:0] MODE_LATIN1 = 2'd0;
  localparam logic [1:0] MODE_UTF16  = 2'd1;
  localparam logic [1:0] MODE_PASS   = 2'd2;
  localparam logic [1:0] MODE_IGNORE = 2'd3;

  localparam logic [7:0] ENC_LATIN1   = 8'd0;
  localparam logic [7:0] ENC_UTF16    = 8'd1;
  localparam logic [7:0] ENC_UTF16_BE = 8'd2;
  localparam logic [7:0] ENC_UTF8     = 8'd3;

  localparam logic [7:0] BOM_FF     = 8'hFF;
  localparam logic [7:0] BOM_FE     = 8'hFE;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] DEL_BYTE   = 8'h7F;

  localparam logic [5:0] HI_SUR_TAG = 6'b110110;
  localparam logic [5:0] LO_SUR_TAG = 6'b110111;

  localparam logic [CP_W-1:0] REPL_CP   = 21'h00FFFD;
  localparam logic [CP_W-1:0] SUPP_BASE = 21'h010000;

  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_first;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic            fffd_first;
    logic            code_valid;
    logic [CP_W-1:0] code;
    logic            raw_valid;
    logic [7:0]      raw_byte;
  } plan_t;

  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [CNT_W-1:0]        count;
  } run_t;

endpackage

`default_nettype wire

// File: sv/id3u8_decode.sv
`default_nettype none

module id3u8_decode
  import id3u8_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     advance,
  input  wire in_item_t item,
  output plan_t         plan
);

  logic [1:0] mode, mode_next;
  logic       stopped, stopped_next;
  logic       half_valid, half_valid_next;
  logic [7:0] held_byte, held_byte_next;
  logic       little_endian, little_endian_next;
  logic       bom_pending, bom_pending_next;
  logic       hs_valid, hs_valid_next;
  logic [9:0] hs_bits, hs_bits_next;

  logic [7:0]  b;
  logic [15:0] unit;
  logic        is_high;
  logic        is_low;
  logic        bom_hit;

  assign b       = item.data_byte;
  assign unit    = little_endian ? {b, held_byte} : {held_byte, b};
  assign is_high = (unit[15:10] == HI_SUR_TAG);
  assign is_low  = (unit[15:10] == LO_SUR_TAG);
  assign bom_hit = ((held_byte == BOM_FF) && (b == BOM_FE)) ||
                   ((held_byte == BOM_FE) && (b == BOM_FF));

  always_comb begin
    mode_next          = mode;
    stopped_next       = stopped;
    half_valid_next    = half_valid;
    held_byte_next     = held_byte;
    little_endian_next = little_endian;
    bom_pending_next   = bom_pending;
    hs_valid_next      = hs_valid;
    hs_bits_next       = hs_bits;
    plan               = '0;
    plan.raw_byte      = (b < CTRL_LIMIT) ? SPACE_BYTE : b;

    if (item.is_first) begin
      case (b) inside
        ENC_LATIN1:             mode_next = MODE_LATIN1;
        ENC_UTF16, ENC_UTF16_BE: mode_next = MODE_UTF16;
        ENC_UTF8:               mode_next = MODE_PASS;
        default:                mode_next = MODE_IGNORE;
      endcase
      stopped_next       = 1'b0;
      half_valid_next    = 1'b0;
      little_endian_next = 1'b0;
      bom_pending_next   = (mode_next == MODE_UTF16);
      hs_valid_next      = 1'b0;
    end else if (!stopped) begin
      case (mode)
        MODE_LATIN1: begin
          if (b == 8'd0) begin
            stopped_next = 1'b1;
          end else begin
            plan.code_valid = 1'b1;
            plan.code       = {{(CP_W-8){1'b0}}, b};
          end
        end
        MODE_PASS: begin
          if (b == 8'd0) begin
            stopped_next = 1'b1;
          end else begin
            plan.raw_valid = 1'b1;
          end
        end
        MODE_UTF16: begin
          if (!half_valid) begin
            held_byte_next  = b;
            half_valid_next = 1'b1;
          end else begin
            half_valid_next  = 1'b0;
            bom_pending_next = 1'b0;
            if (bom_pending && bom_hit) begin
              little_endian_next = (held_byte == BOM_FF);
            end else if (hs_valid && is_low) begin
              hs_valid_next   = 1'b0;
              plan.code_valid = 1'b1;
              plan.code       = SUPP_BASE + {1'b0, hs_bits, unit[9:0]};
            end else begin
              if (hs_valid) begin
                hs_valid_next   = 1'b0;
                plan.fffd_first = 1'b1;
              end
              if (unit == 16'd0) begin
                stopped_next = 1'b1;
              end else if (is_high) begin
                hs_valid_next = 1'b1;
                hs_bits_next  = unit[9:0];
              end else if (is_low) begin
                plan.code_valid = 1'b1;
                plan.code       = REPL_CP;
              end else begin
                plan.code_valid = 1'b1;
                plan.code       = {{(CP_W-16){1'b0}}, unit};
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (item.is_last) begin
      if (!stopped_next && (mode_next == MODE_UTF16) && hs_valid_next) begin
        plan.code_valid = 1'b1;
        plan.code       = REPL_CP;
      end
      stopped_next     = 1'b1;
      half_valid_next  = 1'b0;
      bom_pending_next = 1'b0;
      hs_valid_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IGNORE;
      stopped       <= 1'b0;
      half_valid    <= 1'b0;
      little_endian <= 1'b0;
      bom_pending   <= 1'b0;
      hs_valid      <= 1'b0;
    end else if (advance) begin
      mode          <= mode_next;
      stopped       <= stopped_next;
      half_valid    <= half_valid_next;
      little_endian <= little_endian_next;
      bom_pending   <= bom_pending_next;
      hs_valid      <= hs_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held_byte <= held_byte_next;
      hs_bits   <= hs_bits_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/id3u8_encode.sv
`default_nettype none

module id3u8_encode
  import id3u8_pkg::*;
(
  input  wire plan_t plan,
  output run_t       run
);

  logic [CP_W-1:0] c;
  logic            is_ctrl;
  logic [2:0]      len;
  logic [2:0]      code_len;
  logic [3:0][7:0] cb;

  assign c        = plan.code;
  assign is_ctrl  = (c < CP_W'(32)) || (c == CP_W'(DEL_BYTE));
  assign code_len = plan.code_valid ? len : 3'd0;

  always_comb begin
    cb = '0;
    if (is_ctrl) begin
      len   = 3'd1;
      cb[0] = SPACE_BYTE;
    end else if (c < CP_W'(32'h80)) begin
      len   = 3'd1;
      cb[0] = c[7:0];
    end else if (c < CP_W'(32'h800)) begin
      len   = 3'd2;
      cb[0] = {3'b110, c[10:6]};
      cb[1] = {2'b10, c[5:0]};
    end else if (c < CP_W'(32'h10000)) begin
      len   = 3'd3;
      cb[0] = {4'b1110, c[15:12]};
      cb[1] = {2'b10, c[11:6]};
      cb[2] = {2'b10, c[5:0]};
    end else begin
      len   = 3'd4;
      cb[0] = {5'b11110, c[20:18]};
      cb[1] = {2'b10, c[17:12]};
      cb[2] = {2'b10, c[11:6]};
      cb[3] = {2'b10, c[5:0]};
    end
  end

  always_comb begin
    run = '0;
    if (plan.raw_valid) begin
      run.bytes[0] = plan.raw_byte;
      run.count    = CNT_W'(1);
    end else if (plan.fffd_first) begin
      run.bytes[0] = REPL_B0;
      run.bytes[1] = REPL_B1;
      run.bytes[2] = REPL_B2;
      run.bytes[3] = cb[0];
      run.bytes[4] = cb[1];
      run.bytes[5] = cb[2];
      run.count    = CNT_W'(3) + code_len;
    end else begin
      run.bytes[0] = cb[0];
      run.bytes[1] = cb[1];
      run.bytes[2] = cb[2];
      run.bytes[3] = cb[3];
      run.count    = code_len;
    end
  end

endmodule

`default_nettype wire

// File: sv/id3u8_serial.sv
`default_nettype none

module id3u8_serial
  import id3u8_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire run_t             run_in,
  input  wire logic             result_ready,
  output logic                  result_valid,
  output out_item_t             result,
  output logic                  free,
  output logic [CNT_W-1:0]      count
);

  logic [RUN_MAX-1:0][7:0] bytes;
  logic                    take;

  assign result_valid       = (count != '0);
  assign result.out_byte    = bytes[0];
  assign result.last_of_run = (count == CNT_W'(1));
  assign take               = result_valid && result_ready;
  assign free               = !result_valid || (result.last_of_run && result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= run_in.count;
    end else if (take) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= run_in.bytes;
    end else if (take) begin
      bytes <= {8'h00, bytes[RUN_MAX-1:1]};
    end
  end

endmodule

`default_nettype wire

// File: sv/id3_text_to_utf8_core.sv
// ID3 text frame to UTF-8 converter.
// The item channel (item_valid, item_ready, item) takes one frame byte per beat;
// is_first marks the encoding byte and is_last the final byte of a frame.
// The result channel (result_valid, result_ready, result) gives one UTF-8 byte
// per beat, with last_of_run set on the final byte caused by one input byte.
// A beat is held in an input register, decoded against the frame state once the
// serializer is free and loaded into a six-byte run register that it drains.
// An accepted beat reaches the result port through the input and run registers.
// The block takes one input beat per cycle while each beat yields at most one
// byte and the receiver keeps result_ready high; a beat that yields more bytes
// holds the run register until its last byte is taken, so the serializer's one
// byte per cycle sets the rate. Beats that yield nothing leave the run free.
// Reset empties both registers and puts the frame state in ignore mode until
// an encoding byte arrives.
// When the receiver stalls, the run register holds, the input register fills,
// and item_ready drops until the run register frees up.
`default_nettype none

module id3_text_to_utf8_core
  import id3u8_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      item_valid,
  output logic           item_ready,
  input  wire in_item_t  item,
  output logic           result_valid,
  input  wire logic      result_ready,
  output out_item_t      result
);

  logic             item_held;
  in_item_t         item_reg;
  logic             advance;
  logic             run_free;
  logic [CNT_W-1:0] run_count;
  plan_t            plan;
  run_t             run;

  assign advance    = item_held && run_free;
  assign item_ready = !item_held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_held <= 1'b0;
    end else if (item_ready) begin
      item_held <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      item_reg <= item;
    end
  end

  id3u8_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item_reg),
    .plan    (plan)
  );

  id3u8_encode u_encode (
    .plan (plan),
    .run  (run)
  );

  id3u8_serial u_serial (
    .clk          (clk),
    .rst          (rst),
    .load         (advance),
    .run_in       (run),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result),
    .free         (run_free),
    .count        (run_count)
  );

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    run_count <= CNT_W'(RUN_MAX))
    else $error("run longer than six bytes");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && !result.last_of_run) |=> result_valid)
    else $error("run ended before its last byte");

  a_item_kept: assert property (@(posedge clk) disable iff (rst)
    (item_held && !advance) |=> (item_held && $stable(item_reg)))
    else $error("waiting input beat lost");
`endif

endmodule

`default_nettype wire
